// File: design/cc20_pkg.sv
// Shared types and constants for the ChaCha20 byte-stream cipher unit.
// No dependencies; every other design file imports this package.
package cc20_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_BITS = BLOCK_BYTES * 8;
  localparam int KS_CNT_W = $clog2(BLOCK_BYTES);
  localparam int DOUBLE_ROUNDS = 10;
  localparam int HALF_STEPS = DOUBLE_ROUNDS * 4;
  localparam int STEP_W = $clog2(HALF_STEPS);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LOW = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HIGH = 3'd5;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_low;
    logic [31:0]      nonce_high;
  } cfg_regs_t;

  typedef struct packed {
    logic take;
    logic restart;
  } ks_ctrl_t;

  typedef struct packed {
    logic                  ready;
    logic [BLOCK_BITS-1:0] block;
  } ks_status_t;

endpackage

// File: design/chacha20_stream_cipher_unit.sv
// Top level of the ChaCha20 byte-stream cipher: configuration registers and
// wiring of cc20_in_queue, cc20_core and cc20_xor_stage. Depends on cc20_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   text     | text_valid / text_ready    | text (data_in, last_in)
//   result   | result_valid / result_ready| result (data_out, last_out)
//   cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One byte per cycle sustained while the result side accepts; an accepted
// request passes through the queue memory and then the result register.
// The round unit works on the next 64-byte block while the current one is
// consumed. After reset or a key or nonce write, requests wait in the
// queue until the first block is ready. A stalled result side fills the
// queue and then drops text_ready.
module chacha20_stream_cipher_unit import cc20_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_ready,
  input  in_item_t               text,
  output logic                   result_valid,
  input  logic                   result_ready,
  output out_item_t              result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  cfg_regs_t  cfg;
  ks_ctrl_t   ctrl;
  ks_status_t status;
  logic       restart;
  logic       head_valid;
  logic       head_pop;
  in_item_t   head_item;
  logic       take;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_index) inside
      CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3, CFG_NONCE_LOW, CFG_NONCE_HIGH: begin
        restart = cfg_valid;
      end
      default: begin
        restart = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY0: cfg.key[0] <= cfg_data;
        CFG_KEY1: cfg.key[1] <= cfg_data;
        CFG_KEY2: cfg.key[2] <= cfg_data;
        CFG_KEY3: cfg.key[3] <= cfg_data;
        CFG_NONCE_LOW: cfg.nonce_low <= cfg_data;
        CFG_NONCE_HIGH: cfg.nonce_high <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  assign ctrl.take = take;
  assign ctrl.restart = restart;

  cc20_in_queue #(
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(text_valid),
    .push_ready(text_ready),
    .push_item (text),
    .pop_valid (head_valid),
    .pop_ready (head_pop),
    .pop_item  (head_item)
  );

  cc20_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .ctrl  (ctrl),
    .status(status)
  );

  cc20_xor_stage u_xor (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .head_valid  (head_valid),
    .head_pop    (head_pop),
    .head_item   (head_item),
    .status      (status),
    .take        (take),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// File: design/cc20_in_queue.sv
// Front end: small request queue between the input channel and the XOR stage.
// Depends on cc20_pkg for the request item type.
module cc20_in_queue import cc20_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  in_item_t push_item,
  output logic     pop_valid,
  input  logic     pop_ready,
  output in_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  in_item_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             push;
  logic             pop;

  assign push_ready = (cnt != CNT_FULL);
  assign pop_valid = (cnt != '0);
  assign pop_item = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("request queue count did not follow a lone push");

endmodule

// File: design/cc20_core.sv
// Keystream block generator: one half quarter-round on all four columns or
// diagonals per cycle, then the feed-forward add. Depends on cc20_pkg.
module cc20_core import cc20_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  ks_ctrl_t   ctrl,
  output ks_status_t status
);

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_ROUND = 2'd1;
  localparam logic [1:0] PH_FEED = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HALF_STEPS - 1);

  logic [1:0]        phase;
  logic [STEP_W-1:0] step;
  logic [31:0]       ctr;
  logic [31:0]       w [16];
  logic [31:0]       w_next [16];
  logic [31:0]       init [16];

  always_comb begin
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2 * k] = cfg.key[k][31:0];
      init[5 + 2 * k] = cfg.key[k][63:32];
    end
    init[12] = ctr;
    init[13] = cfg.nonce_low[31:0];
    init[14] = cfg.nonce_low[63:32];
    init[15] = cfg.nonce_high;
  end

  // step[0] selects the second half of the quarter-round, step[1] the diagonals.
  always_comb begin
    logic [1:0]  qc;
    logic [1:0]  qb;
    logic [1:0]  qcc;
    logic [1:0]  qd;
    logic [3:0]  ia;
    logic [3:0]  ib;
    logic [3:0]  ic;
    logic [3:0]  id;
    logic [31:0] a1;
    logic [31:0] b1;
    logic [31:0] c1;
    logic [31:0] d1;
    for (int i = 0; i < 16; i++) begin
      w_next[i] = w[i];
    end
    for (int q = 0; q < 4; q++) begin
      qc = 2'(q);
      qb = step[1] ? qc + 2'd1 : qc;
      qcc = step[1] ? qc + 2'd2 : qc;
      qd = step[1] ? qc + 2'd3 : qc;
      ia = {2'd0, qc};
      ib = {2'd1, qb};
      ic = {2'd2, qcc};
      id = {2'd3, qd};
      a1 = w[ia] + w[ib];
      d1 = w[id] ^ a1;
      d1 = step[0] ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
      c1 = w[ic] + d1;
      b1 = w[ib] ^ c1;
      b1 = step[0] ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
      w_next[ia] = a1;
      w_next[ib] = b1;
      w_next[ic] = c1;
      w_next[id] = d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOAD;
      ctr <= '0;
      step <= '0;
    end else if (ctrl.restart) begin
      phase <= PH_LOAD;
      ctr <= '0;
    end else begin
      unique case (phase)
        PH_LOAD: begin
          step <= '0;
          phase <= PH_ROUND;
        end
        PH_ROUND: begin
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            phase <= PH_FEED;
          end
        end
        PH_FEED: begin
          phase <= PH_DONE;
        end
        PH_DONE: begin
          if (ctrl.take) begin
            ctr <= ctr + 1'b1;
            phase <= PH_LOAD;
          end
        end
        default: begin
          phase <= PH_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      if (phase == PH_LOAD) begin
        w[i] <= init[i];
      end else if (phase == PH_ROUND) begin
        w[i] <= w_next[i];
      end else if (phase == PH_FEED) begin
        w[i] <= w[i] + init[i];
      end
    end
  end

  always_comb begin
    status.ready = (phase == PH_DONE);
    for (int i = 0; i < 16; i++) begin
      status.block[32 * i +: 32] = w[i];
    end
  end

  a_take_done: assert property (@(posedge clk) disable iff (rst)
    ctrl.take |-> phase == PH_DONE)
    else $error("keystream block taken before it was finished");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.restart |=> (phase == PH_LOAD) && (ctr == '0))
    else $error("restart did not return the generator to block zero");

endmodule

// File: design/cc20_xor_stage.sv
// Back end: keystream shift buffer, byte XOR and the result register.
// Depends on cc20_pkg; takes finished blocks from cc20_core.
module cc20_xor_stage import cc20_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  logic       head_valid,
  output logic       head_pop,
  input  in_item_t   head_item,
  input  ks_status_t status,
  output logic       take,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result
);

  localparam logic [KS_CNT_W-1:0] CNT_FULL = KS_CNT_W'(BLOCK_BYTES - 1);

  logic [BLOCK_BITS-1:0] sh;
  logic [KS_CNT_W-1:0]   ks_cnt;
  logic                  buf_empty;
  logic                  avail;
  logic                  fire;
  logic [7:0]            ks_byte;

  assign buf_empty = (ks_cnt == '0);
  assign avail = !buf_empty || status.ready;
  assign fire = head_valid && avail && (!result_valid || result_ready);
  assign head_pop = fire;
  assign take = fire && buf_empty;
  assign ks_byte = buf_empty ? status.block[7:0] : sh[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      if (restart) begin
        ks_cnt <= '0;
      end else if (fire) begin
        ks_cnt <= buf_empty ? CNT_FULL : ks_cnt - 1'b1;
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sh <= buf_empty ? (status.block >> 8) : (sh >> 8);
      result.data_out <= head_item.data_in ^ ks_byte;
      result.last_out <= head_item.last_in;
    end
  end

  a_take_ready: assert property (@(posedge clk) disable iff (rst)
    take |-> status.ready)
    else $error("keystream byte used from an unfinished block");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    (take && !restart) |=> ks_cnt == CNT_FULL)
    else $error("keystream buffer not refilled after taking a block");

endmodule
